>>> rtl/core/flat_triangle_normal_emit_defines.svh
// Assertion macros used by the triangle normal emitter checker.
`ifndef FLAT_TRIANGLE_NORMAL_EMIT_DEFINES_SVH
`define FLAT_TRIANGLE_NORMAL_EMIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FTN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ftn check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FTN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ftn check failed");

`endif

>>> rtl/core/ftn_pkg.sv
// Types and constants of the triangle normal emitter.
`default_nettype none
package ftn_pkg;

  localparam int COORD_W   = 16;
  localparam int NORM_FRAC = 14;
  localparam int INDEX_W   = 32;
  localparam int COLOR_W   = 32;

  localparam int NORM_W  = NORM_FRAC + 2;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int CROSS_W = 2 * DIFF_W + 1;
  localparam int CM_W    = 31;
  localparam int MAC_W   = 32;
  localparam int ACC_W   = 2 * MAC_W + 2;
  localparam int SUM_W   = 2 * CM_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int Q_W     = NORM_FRAC + 1;
  localparam int NUM_W   = CM_W + NORM_FRAC + 1;

  localparam logic signed [NORM_W-1:0] NORM_ONE     = NORM_W'(1) <<< NORM_FRAC;
  localparam logic signed [NORM_W-1:0] NORM_NEG_ONE = -NORM_ONE;
  localparam logic [INDEX_W-1:0]       IDX_STEP     = INDEX_W'(1);

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [COLOR_W-1:0]        color;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [NORM_W-1:0]  norm_x;
    logic signed [NORM_W-1:0]  norm_y;
    logic signed [NORM_W-1:0]  norm_z;
    logic [COLOR_W-1:0]        vertex_color;
    logic [INDEX_W-1:0]        vertex_index;
    logic                      last_of_triangle;
  } out_t;

  typedef struct packed {
    logic vld;
    logic clr;
    logic sub;
  } mac_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CROSS,
    ST_NORM,
    ST_SQUARE,
    ST_SQRT,
    ST_DIVGO,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

>>> rtl/core/ftn_mac.sv
// Shared signed multiply-accumulate unit with a registered product.
`default_nettype none
module ftn_mac (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire ftn_pkg::mac_ctl_t                      ctl,
  input  wire logic signed [ftn_pkg::MAC_W-1:0]       op_a,
  input  wire logic signed [ftn_pkg::MAC_W-1:0]       op_b,
  output logic signed [ftn_pkg::ACC_W-1:0]            acc
);

  localparam int PW = 2 * ftn_pkg::MAC_W;

  logic signed [PW-1:0]             prod_r;
  ftn_pkg::mac_ctl_t                ctl_r;
  logic signed [ftn_pkg::ACC_W-1:0] acc_r;
  logic signed [ftn_pkg::ACC_W-1:0] prod_ext;
  logic signed [ftn_pkg::ACC_W-1:0] base;

  assign prod_ext = {{(ftn_pkg::ACC_W - PW){prod_r[PW-1]}}, prod_r};
  assign base     = ctl_r.clr ? '0 : acc_r;
  assign acc      = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (ctl_r.vld) begin
      acc_r <= ctl_r.sub ? (base - prod_ext) : (base + prod_ext);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ftn_sqrt.sv
// Integer square root, one result bit per cycle.
`default_nettype none
module ftn_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ftn_pkg::SUM_W-1:0]    rad,
  output logic                              done,
  output logic [ftn_pkg::ROOT_W-1:0]        root
);

  localparam int RW    = ftn_pkg::ROOT_W;
  localparam int SW    = ftn_pkg::SUM_W;
  localparam int CNT_W = $clog2(RW);

  logic [SW-1:0]    rad_r;
  logic [RW:0]      rem_r;
  logic [RW-1:0]    root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [RW+1:0]    rem_sh;
  logic [RW+1:0]    trial;
  logic             ge;

  // bring down the next pair of radicand bits and try root*4+1
  assign rem_sh = {rem_r[RW-1:0], rad_r[SW-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign done   = done_r;
  assign root   = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == CNT_W'(RW - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (run_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
      root_r <= {root_r[RW-2:0], ge};
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ftn_div.sv
// Restoring divider for the normal components, one quotient bit per cycle.
`default_nettype none
module ftn_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ftn_pkg::NUM_W-1:0]    num,
  input  wire logic [ftn_pkg::ROOT_W-1:0]   den,
  output logic                              done,
  output logic [ftn_pkg::Q_W-1:0]           quo
);

  localparam int RW    = ftn_pkg::ROOT_W;
  localparam int QW    = ftn_pkg::Q_W;
  localparam int CNT_W = $clog2(QW);

  logic [RW-1:0]    den_r;
  logic [RW-1:0]    rem_r;
  logic [QW-1:0]    qr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [RW:0]      rem_sh;
  logic             ge;

  // low numerator bits shift out of qr_r while quotient bits shift in
  assign rem_sh = {rem_r, qr_r[QW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign done   = done_r;
  assign quo    = qr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == CNT_W'(QW - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= RW'(num[ftn_pkg::NUM_W-1:QW]);
      qr_r  <= num[QW-1:0];
      cnt_r <= '0;
    end else if (run_r) begin
      rem_r <= ge ? RW'(rem_sh - {1'b0, den_r}) : RW'(rem_sh);
      qr_r  <= {qr_r[QW-2:0], ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/flat_triangle_normal_emit.sv
// Top level of the flat-shaded triangle normal emitter.
// Takes one triangle (three Q8.8 vertices and a colour) and emits three vertex
// beats a, b, c carrying the unit face normal in Q1.14, the colour, a running
// vertex index that wraps at 2^32, and a last flag on the third beat. A
// degenerate triangle (zero cross product) gets normal (0, 1.0, 0). One
// triangle is worked at a time and in_ready is high only while idle. A
// triangle passes in order through the edge differences, the cross product on
// the shared multiply-accumulate unit, the one-bit-per-cycle normalising shift,
// the sum of squares, the bit-serial square root, the three restoring divides
// and the output beats, which out_ready can stall; a degenerate triangle skips
// the squares, the root and the divides. The block returns to idle before the
// next triangle is taken.
`default_nettype none
module flat_triangle_normal_emit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ftn_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ftn_pkg::out_t      out_data
);

  localparam int DW  = ftn_pkg::DIFF_W;
  localparam int CW  = ftn_pkg::CROSS_W;
  localparam int MW  = ftn_pkg::CM_W;
  localparam int NW  = ftn_pkg::NORM_W;
  localparam int F   = ftn_pkg::NORM_FRAC;

  ftn_pkg::state_t state_r, state_nxt;

  ftn_pkg::in_t              tri_r;
  logic signed [DW-1:0]      d_r [6];
  logic [CW-1:0]             cm_r [3];
  logic                      cn_r [3];
  logic signed [NW-1:0]      norm_r [3];
  logic [2:0]                step_r;
  logic [1:0]                comp_r;
  logic [1:0]                beat_r;
  logic [ftn_pkg::INDEX_W-1:0] vcnt_r;

  ftn_pkg::mac_ctl_t                   mac_ctl;
  logic signed [ftn_pkg::MAC_W-1:0]    mac_a, mac_b;
  logic signed [ftn_pkg::ACC_W-1:0]    acc;
  logic                                sqrt_start, sqrt_done;
  logic [ftn_pkg::ROOT_W-1:0]          len;
  logic                                div_start, div_done;
  logic [ftn_pkg::NUM_W-1:0]           div_num;
  logic [ftn_pkg::Q_W-1:0]             quo;

  logic                 cm_zero, cm_high, cm_top;
  logic signed [CW-1:0] cr;
  logic                 out_fire;

  ftn_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  ftn_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sqrt_start),
    .rad  (acc[ftn_pkg::SUM_W-1:0]),
    .done (sqrt_done),
    .root (len)
  );

  ftn_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (len),
    .done (div_done),
    .quo  (quo)
  );

  assign cm_zero  = ~|{cm_r[0], cm_r[1], cm_r[2]};
  assign cm_high  = |{cm_r[0][CW-1:MW], cm_r[1][CW-1:MW], cm_r[2][CW-1:MW]};
  assign cm_top   = cm_r[0][MW-1] | cm_r[1][MW-1] | cm_r[2][MW-1];
  assign cr       = acc[CW-1:0];
  assign out_fire = out_valid && out_ready;
  assign div_num  = ftn_pkg::NUM_W'({cm_r[comp_r][MW-1:0], {F{1'b0}}})
                  + ftn_pkg::NUM_W'(len >> 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ftn_pkg::ST_IDLE:   if (in_valid) state_nxt = ftn_pkg::ST_DIFF;
      ftn_pkg::ST_DIFF:   state_nxt = ftn_pkg::ST_CROSS;
      ftn_pkg::ST_CROSS:  if (step_r == 3'd7) state_nxt = ftn_pkg::ST_NORM;
      ftn_pkg::ST_NORM: begin
        if (cm_zero) begin
          state_nxt = ftn_pkg::ST_EMIT;
        end else if (!cm_high && cm_top) begin
          state_nxt = ftn_pkg::ST_SQUARE;
        end
      end
      ftn_pkg::ST_SQUARE: if (step_r == 3'd4) state_nxt = ftn_pkg::ST_SQRT;
      ftn_pkg::ST_SQRT:   if (sqrt_done) state_nxt = ftn_pkg::ST_DIVGO;
      ftn_pkg::ST_DIVGO:  state_nxt = ftn_pkg::ST_DIV;
      ftn_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = (comp_r == 2'd2) ? ftn_pkg::ST_EMIT : ftn_pkg::ST_DIVGO;
        end
      end
      ftn_pkg::ST_EMIT:   if (out_fire && beat_r == 2'd2) state_nxt = ftn_pkg::ST_IDLE;
      default:            state_nxt = ftn_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    mac_ctl    = '0;
    mac_a      = '0;
    mac_b      = '0;
    case (state_r)
      ftn_pkg::ST_IDLE: in_ready = 1'b1;
      ftn_pkg::ST_CROSS: begin
        mac_ctl.vld = step_r < 3'd6;
        mac_ctl.clr = ~step_r[0];
        mac_ctl.sub = step_r[0];
        case (step_r)
          3'd0:    begin mac_a = 32'(d_r[1]); mac_b = 32'(d_r[5]); end
          3'd1:    begin mac_a = 32'(d_r[2]); mac_b = 32'(d_r[4]); end
          3'd2:    begin mac_a = 32'(d_r[2]); mac_b = 32'(d_r[3]); end
          3'd3:    begin mac_a = 32'(d_r[0]); mac_b = 32'(d_r[5]); end
          3'd4:    begin mac_a = 32'(d_r[0]); mac_b = 32'(d_r[4]); end
          3'd5:    begin mac_a = 32'(d_r[1]); mac_b = 32'(d_r[3]); end
          default: begin mac_a = '0; mac_b = '0; end
        endcase
      end
      ftn_pkg::ST_SQUARE: begin
        mac_ctl.vld = step_r < 3'd3;
        mac_ctl.clr = step_r == 3'd0;
        if (step_r < 3'd3) begin
          mac_a = $signed({1'b0, cm_r[step_r[1:0]][MW-1:0]});
          mac_b = $signed({1'b0, cm_r[step_r[1:0]][MW-1:0]});
        end
        sqrt_start = step_r == 3'd4;
      end
      ftn_pkg::ST_DIVGO: div_start = 1'b1;
      ftn_pkg::ST_EMIT:  out_valid = 1'b1;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_data.norm_x           = norm_r[0];
    out_data.norm_y           = norm_r[1];
    out_data.norm_z           = norm_r[2];
    out_data.vertex_color     = tri_r.color;
    out_data.vertex_index     = vcnt_r;
    out_data.last_of_triangle = beat_r == 2'd2;
    case (beat_r)
      2'd0: begin
        out_data.pos_x = tri_r.ax; out_data.pos_y = tri_r.ay; out_data.pos_z = tri_r.az;
      end
      2'd1: begin
        out_data.pos_x = tri_r.bx; out_data.pos_y = tri_r.by; out_data.pos_z = tri_r.bz;
      end
      default: begin
        out_data.pos_x = tri_r.cx; out_data.pos_y = tri_r.cy; out_data.pos_z = tri_r.cz;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ftn_pkg::ST_IDLE;
      step_r  <= '0;
      comp_r  <= '0;
      beat_r  <= '0;
      vcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= (state_nxt != state_r) ? 3'd0 : step_r + 3'd1;
      if (state_r == ftn_pkg::ST_SQRT) begin
        comp_r <= '0;
      end else if (state_r == ftn_pkg::ST_DIV && div_done) begin
        comp_r <= comp_r + 2'd1;
      end
      if (out_fire) begin
        beat_r <= (beat_r == 2'd2) ? 2'd0 : beat_r + 2'd1;
        vcnt_r <= vcnt_r + ftn_pkg::IDX_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tri_r <= in_data;
    end
    if (state_r == ftn_pkg::ST_DIFF) begin
      d_r[0] <= DW'(tri_r.bx) - DW'(tri_r.ax);
      d_r[1] <= DW'(tri_r.by) - DW'(tri_r.ay);
      d_r[2] <= DW'(tri_r.bz) - DW'(tri_r.az);
      d_r[3] <= DW'(tri_r.cx) - DW'(tri_r.ax);
      d_r[4] <= DW'(tri_r.cy) - DW'(tri_r.ay);
      d_r[5] <= DW'(tri_r.cz) - DW'(tri_r.az);
    end
    // each cross component lands once its second product has passed through the product register and the accumulator
    if (state_r == ftn_pkg::ST_CROSS && step_r[0] && step_r != 3'd1) begin
      cm_r[2'(step_r[2:1] - 2'd1)] <= cr[CW-1] ? CW'(-cr) : CW'(cr);
      cn_r[2'(step_r[2:1] - 2'd1)] <= cr[CW-1];
    end
    if (state_r == ftn_pkg::ST_NORM) begin
      if (cm_zero) begin
        norm_r[0] <= '0;
        norm_r[1] <= ftn_pkg::NORM_ONE;
        norm_r[2] <= '0;
      end else if (cm_high) begin
        for (int i = 0; i < 3; i++) cm_r[i] <= cm_r[i] >> 1;
      end else if (!cm_top) begin
        for (int i = 0; i < 3; i++) cm_r[i] <= cm_r[i] << 1;
      end
    end
    if (state_r == ftn_pkg::ST_DIV && div_done) begin
      norm_r[comp_r] <= cn_r[comp_r] ? -$signed(NW'(quo)) : $signed(NW'(quo));
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ftn_checker.sv
// Port-level checker for the triangle normal emitter, bound to the top level.
`default_nettype none
`include "flat_triangle_normal_emit_defines.svh"
module ftn_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire ftn_pkg::out_t out_data
);

  logic out_beat;
  logic last_beat;
  logic idx_inc;
  logic nx_ok, ny_ok, nz_ok;
  logic [ftn_pkg::INDEX_W-1:0] idx_prev_r;

  always_ff @(posedge clk) begin
    idx_prev_r <= out_data.vertex_index;
  end

  assign out_beat  = out_valid && out_ready;
  assign last_beat = out_data.last_of_triangle;
  assign idx_inc   = (out_data.vertex_index - idx_prev_r) == ftn_pkg::IDX_STEP;
  assign nx_ok = out_data.norm_x <= ftn_pkg::NORM_ONE
              && out_data.norm_x >= ftn_pkg::NORM_NEG_ONE;
  assign ny_ok = out_data.norm_y <= ftn_pkg::NORM_ONE
              && out_data.norm_y >= ftn_pkg::NORM_NEG_ONE;
  assign nz_ok = out_data.norm_z <= ftn_pkg::NORM_ONE
              && out_data.norm_z >= ftn_pkg::NORM_NEG_ONE;

  `FTN_ASSERT_IMP(a_no_overlap, in_ready, !out_valid)
  `FTN_ASSERT_NXT(a_idle_after_last, out_beat && last_beat, in_ready)
  `FTN_ASSERT_NXT(a_index_step, out_beat && !last_beat, out_valid && idx_inc)
  `FTN_ASSERT_IMP(a_norm_range, out_valid, nx_ok && ny_ok && nz_ok)
  `FTN_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind flat_triangle_normal_emit ftn_checker u_ftn_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
`default_nettype wire

>>> dv/flat_triangle_normal_emit_test.sv
// Testbench of the triangle normal emitter: predicted vertex beats checked against the block.
module flat_triangle_normal_emit_test;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  ftn_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  ftn_pkg::out_t out_data;

  flat_triangle_normal_emit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  ftn_pkg::out_t   vertex_q[$];
  logic [31:0]     next_index;
  int              mismatches = 0;
  int              hold_off_cycles;
  int              long_hold_req;
  int              long_hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic longint unsigned isqrt_u64(longint unsigned n);
    longint unsigned root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  // Unit face normal of (b-a)x(c-a), Q1.14, with the degenerate fallback.
  function automatic void face_normal(input ftn_pkg::in_t t,
                                      output logic signed [ftn_pkg::NORM_W-1:0] n[3]);
    longint d[6];
    longint cr[3];
    longint unsigned cm[3];
    longint unsigned mx, sum, len, q;
    bit neg[3];
    d[0] = longint'(t.bx) - t.ax;
    d[1] = longint'(t.by) - t.ay;
    d[2] = longint'(t.bz) - t.az;
    d[3] = longint'(t.cx) - t.ax;
    d[4] = longint'(t.cy) - t.ay;
    d[5] = longint'(t.cz) - t.az;
    cr[0] = d[1] * d[5] - d[2] * d[4];
    cr[1] = d[2] * d[3] - d[0] * d[5];
    cr[2] = d[0] * d[4] - d[1] * d[3];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = cr[i] < 0;
      cm[i] = neg[i] ? -cr[i] : cr[i];
      if (cm[i] > mx) mx = cm[i];
    end
    if (mx == 0) begin
      n[0] = '0;
      n[1] = ftn_pkg::NORM_ONE;
      n[2] = '0;
      return;
    end
    while (mx >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) cm[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) cm[i] <<= 1;
      mx <<= 1;
    end
    sum = cm[0] * cm[0] + cm[1] * cm[1] + cm[2] * cm[2];
    len = isqrt_u64(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((cm[i] << ftn_pkg::NORM_FRAC) + (len >> 1)) / len;
      if (q > (64'd1 << ftn_pkg::NORM_FRAC)) q = 64'd1 << ftn_pkg::NORM_FRAC;
      n[i] = neg[i] ? -ftn_pkg::NORM_W'(q) : ftn_pkg::NORM_W'(q);
    end
  endfunction

  function automatic void predict_vertices(input ftn_pkg::in_t t);
    logic signed [ftn_pkg::NORM_W-1:0] n[3];
    ftn_pkg::out_t v;
    face_normal(t, n);
    for (int k = 0; k < 3; k++) begin
      case (k)
        0: begin v.pos_x = t.ax; v.pos_y = t.ay; v.pos_z = t.az; end
        1: begin v.pos_x = t.bx; v.pos_y = t.by; v.pos_z = t.bz; end
        default: begin v.pos_x = t.cx; v.pos_y = t.cy; v.pos_z = t.cz; end
      endcase
      v.norm_x = n[0];
      v.norm_y = n[1];
      v.norm_z = n[2];
      v.vertex_color = t.color;
      v.vertex_index = next_index + 32'(k);
      v.last_of_triangle = (k == 2);
      vertex_q = {vertex_q, v};
    end
    next_index += 3;
  endfunction

  task automatic idle_gap(input int long_pct);
    int n;
    n = ($urandom_range(99) < long_pct) ? $urandom_range(60, 20) :
        ($urandom_range(1) ? 0 : $urandom_range(3));
    repeat (n) @(posedge clk);
  endtask

  task automatic send_triangle(input ftn_pkg::in_t t, input bit gaps);
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_vertices(t);
    in_valid <= 1'b0;
    // the block stays busy long after accepting a triangle, so the idle edge here costs nothing
    @(posedge clk);
    if (gaps) idle_gap(5);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (vertex_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  function automatic ftn_pkg::in_t random_triangle();
    ftn_pkg::in_t t;
    logic [15:0] span;
    t.color = $urandom;
    case ($urandom_range(3))
      0: span = 16'hffff;
      1: span = 16'h00ff;
      2: span = 16'h000f;
      default: span = 16'h0003;
    endcase
    t.ax = 16'($urandom);
    t.ay = 16'($urandom);
    t.az = 16'($urandom);
    // Near-vertices keep many edges small; full span exercises the extremes.
    t.bx = t.ax + (16'($urandom) & span);
    t.by = t.ay + (16'($urandom) & span);
    t.bz = t.az + (16'($urandom) & span);
    t.cx = t.ax - (16'($urandom) & span);
    t.cy = t.ay + (16'($urandom) & span);
    t.cz = t.az - (16'($urandom) & span);
    if ($urandom_range(15) == 0) {t.cx, t.cy, t.cz} = {t.bx, t.by, t.bz};
    return t;
  endfunction

  task automatic test_directed();
    ftn_pkg::in_t t;
    t = '0;
    send_triangle(t, 1'b0);                      // all at origin: degenerate
    t.color = 32'hffff_ffff; t.bx = 16'sh0100; t.cy = 16'sh0100;
    send_triangle(t, 1'b0);                      // +z normal
    t.bx = 16'sh7fff; t.cy = 16'sh7fff; t.ax = 16'sh8000; t.ay = 16'sh8000;
    send_triangle(t, 1'b1);
    t = '0; t.ax = 16'sh8000; t.ay = 16'sh8000; t.az = 16'sh8000;
    t.bx = 16'sh7fff; t.by = 16'sh8000; t.bz = 16'sh7fff;
    t.cx = 16'sh8000; t.cy = 16'sh7fff; t.cz = 16'sh7fff; t.color = 32'h8000_0001;
    send_triangle(t, 1'b0);
    t = '0; t.by = 16'sh0001; t.cz = 16'sh0001;  // smallest non-degenerate
    send_triangle(t, 1'b1);
    t = '0; t.bx = 16'sh0002; t.cx = 16'sh0004; t.by = 16'sh0001; t.cy = 16'sh0002;
    send_triangle(t, 1'b0);                      // collinear: degenerate
    t = '0; t.bz = 16'sh7fff; t.cx = 16'sh8000; t.color = 32'h1234_5678;
    send_triangle(t, 1'b1);
    t = '0; t.bx = 16'sh0003; t.by = 16'sh0004; t.cz = -16'sh0005;
    send_triangle(t, 1'b0);
    t = '0; t.bx = 16'sh7fff; t.by = 16'sh7fff; t.bz = 16'sh7fff;
    t.cx = 16'sh8000; t.cy = 16'sh7fff; t.cz = 16'sh8000;
    send_triangle(t, 1'b1);
    wait_drained();
  endtask

  task automatic test_random();
    for (int i = 0; i < 120; i++) send_triangle(random_triangle(), ($urandom_range(4) != 0));
    wait_drained();
  endtask

  // Receiver stalls for a long stretch while triangles keep coming.
  task automatic test_backpressure();
    long_hold_req++;
    for (int i = 0; i < 20; i++) send_triangle(random_triangle(), 1'b0);
    wait_drained();
  endtask

  // Sender pauses every so often until every predicted beat has come out.
  task automatic test_drain_pauses();
    for (int i = 0; i < 100; i++) begin
      send_triangle(random_triangle(), 1'b1);
      if (i % 25 == 24) wait_drained();
    end
    wait_drained();
  endtask

  // Receiver: random stalls, or one long hold-off counted here when the test asks.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_off_cycles <= 0;
      long_hold_done <= 0;
    end else if (long_hold_done != long_hold_req) begin
      long_hold_done <= long_hold_req;
      hold_off_cycles <= 600;
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      case ($urandom_range(19))
        0, 1, 2, 3: out_ready <= 1'b0;
        4: begin
          out_ready <= 1'b0;
          hold_off_cycles <= $urandom_range(40, 10);
        end
        default: out_ready <= 1'b1;
      endcase
    end
  end

  // Check each beat against the oldest predicted vertex.
  always @(posedge clk) begin
    ftn_pkg::out_t exp_v;
    if (rst_n && out_valid && out_ready) begin
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", out_data);
      end else begin
        exp_v = vertex_q.pop_front();
        if (out_data !== exp_v) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_v, out_data);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    next_index = '0;
    long_hold_req = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_drain_pauses();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && vertex_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
